// ===== hw/rtl/limit_order_matching_top_assert.svh =====
// Assertion macros for the limit order matching block.
`ifndef LIMIT_ORDER_MATCHING_TOP_ASSERT_SVH
`define LIMIT_ORDER_MATCHING_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LOM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LOM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lom_pkg.sv =====
// Types, constants and helper functions shared by the order matching block.
package lom_pkg;

  localparam int BOOK_SLOTS = 32;
  localparam int IDX_W      = $clog2(BOOK_SLOTS);
  localparam int CNT_W      = $clog2(BOOK_SLOTS + 1);
  localparam int MEM_AW     = IDX_W + 1;
  localparam int ID_W       = 32;
  localparam int PRICE_W    = 24;
  localparam int QTY_W      = 32;

  typedef enum logic [1:0] {
    KIND_TRADE  = 2'd0,
    KIND_FILLED = 2'd1,
    KIND_RESTED = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef struct packed {
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic               is_buy;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
    logic [ID_W-1:0]    id;
  } order_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    taker;
    logic [ID_W-1:0]    maker;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               last;
  } result_t;

  typedef struct packed {
    logic              re;
    logic [MEM_AW-1:0] raddr;
    logic              we;
    logic [MEM_AW-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] ring_idx(logic [IDX_W-1:0] head,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, off};
    if (s >= (CNT_W + 1)'(BOOK_SLOTS)) s = s - (CNT_W + 1)'(BOOK_SLOTS);
    return s[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lom_book_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module lom_book_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lom_engine.sv =====
// Matching and insertion sequencer working on the book memory.
module lom_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lom_pkg::order_t   order_i,
  output lom_pkg::mem_req_t mem_req_o,
  input  lom_pkg::entry_t   rd_i,
  output logic              emit_valid_o,
  output lom_pkg::result_t  emit_o,
  input  logic              out_free_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_MRD, S_MCHK, S_CLOSE, S_IRD, S_ICHK, S_EMIT
  } state_e;

  state_e                       state_q;
  logic [lom_pkg::ID_W-1:0]     id_q;
  logic                         buy_q;
  logic [lom_pkg::PRICE_W-1:0]  price_q;
  logic [lom_pkg::QTY_W-1:0]    remain_q;
  logic [lom_pkg::IDX_W-1:0]    head_q [2];
  logic [lom_pkg::CNT_W-1:0]    cnt_q  [2];
  logic [lom_pkg::CNT_W-1:0]    pos_q;
  lom_pkg::kind_e               kind_q;

  logic                         opp;
  logic                         crosses;
  logic                         behind;
  logic                         drop;
  logic [lom_pkg::QTY_W-1:0]    fill;
  logic [lom_pkg::IDX_W-1:0]    ins_idx;
  logic [lom_pkg::IDX_W-1:0]    src_idx;
  lom_pkg::entry_t              new_entry;

  assign opp       = ~buy_q;
  assign crosses   = buy_q ? (rd_i.price <= price_q) : (rd_i.price >= price_q);
  assign behind    = buy_q ? (rd_i.price >= price_q) : (rd_i.price <= price_q);
  assign fill      = (remain_q < rd_i.qty) ? remain_q : rd_i.qty;
  assign drop      = (rd_i.qty <= remain_q);
  assign ins_idx   = lom_pkg::ring_idx(head_q[buy_q], pos_q);
  assign src_idx   = lom_pkg::ring_idx(head_q[buy_q], pos_q - lom_pkg::CNT_W'(1));
  assign new_entry = '{qty: remain_q, price: price_q, id: id_q};
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    mem_req_o = '0;
    case (state_q)
      S_MRD: begin
        if (remain_q != '0 && cnt_q[opp] != '0) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = {opp, head_q[opp]};
        end
      end
      S_MCHK: begin
        if (crosses && out_free_i && !drop) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = {opp, head_q[opp]};
          mem_req_o.wdata = '{qty: rd_i.qty - fill, price: rd_i.price, id: rd_i.id};
        end
      end
      S_IRD: begin
        if (pos_q == '0) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = {buy_q, ins_idx};
          mem_req_o.wdata = new_entry;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = {buy_q, src_idx};
        end
      end
      S_ICHK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {buy_q, ins_idx};
        mem_req_o.wdata = behind ? new_entry : rd_i;
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_comb begin
    emit_valid_o = 1'b0;
    emit_o       = '{kind: lom_pkg::KIND_TRADE, taker: id_q, maker: rd_i.id,
                     price: rd_i.price, qty: fill, last: 1'b0};
    case (state_q)
      S_MCHK: begin
        emit_valid_o = crosses;
      end
      S_EMIT: begin
        emit_valid_o = 1'b1;
        emit_o.kind  = kind_q;
        emit_o.maker = '0;
        emit_o.price = (kind_q == lom_pkg::KIND_FILLED) ? '0 : price_q;
        emit_o.qty   = (kind_q == lom_pkg::KIND_FILLED) ? '0 : remain_q;
        emit_o.last  = 1'b1;
      end
      default: begin
        emit_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      id_q      <= '0;
      buy_q     <= 1'b0;
      price_q   <= '0;
      remain_q  <= '0;
      head_q[0] <= '0;
      head_q[1] <= '0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      pos_q     <= '0;
      kind_q    <= lom_pkg::KIND_FILLED;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            id_q     <= order_i.id;
            buy_q    <= order_i.is_buy;
            price_q  <= order_i.price;
            remain_q <= order_i.qty;
            state_q  <= S_MRD;
          end
        end
        S_MRD: begin
          state_q <= (remain_q != '0 && cnt_q[opp] != '0) ? S_MCHK : S_CLOSE;
        end
        S_MCHK: begin
          if (!crosses) begin
            state_q <= S_CLOSE;
          end else if (out_free_i) begin
            remain_q <= remain_q - fill;
            if (drop) begin
              head_q[opp] <= lom_pkg::ring_idx(head_q[opp], lom_pkg::CNT_W'(1));
              cnt_q[opp]  <= cnt_q[opp] - lom_pkg::CNT_W'(1);
            end
            state_q <= S_MRD;
          end
        end
        S_CLOSE: begin
          if (remain_q == '0) begin
            kind_q  <= lom_pkg::KIND_FILLED;
            state_q <= S_EMIT;
          end else if (cnt_q[buy_q] == lom_pkg::CNT_W'(lom_pkg::BOOK_SLOTS)) begin
            kind_q  <= lom_pkg::KIND_REJECT;
            state_q <= S_EMIT;
          end else begin
            kind_q  <= lom_pkg::KIND_RESTED;
            pos_q   <= cnt_q[buy_q];
            state_q <= S_IRD;
          end
        end
        S_IRD: begin
          if (pos_q == '0) begin
            cnt_q[buy_q] <= cnt_q[buy_q] + lom_pkg::CNT_W'(1);
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (behind) begin
            cnt_q[buy_q] <= cnt_q[buy_q] + lom_pkg::CNT_W'(1);
            state_q      <= S_EMIT;
          end else begin
            pos_q   <= pos_q - lom_pkg::CNT_W'(1);
            state_q <= S_IRD;
          end
        end
        S_EMIT: begin
          if (out_free_i) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/limit_order_matching_top.sv =====
// Top level of the limit order matching block with its output register.
//
// Channel   Direction  Contents
// s_axis    in         one limit order per request
// m_axis    out        trade and closing results, tlast on the closing one
//
// Each trade and each shifted resting entry needs its own read and check of the book
// memory, since the book memory has a single read port, a single write port and a
// registered read.
// Reset clears the book counts and pointers; memory contents need no clearing.
// A stalled output holds the sequencer only when a new result must be placed.
`include "limit_order_matching_top_assert.svh"
module limit_order_matching_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [87:0]  s_axis_tdata_i,  // order_id, price_ticks, quantity
  input  logic         s_axis_tuser_i,  // is_buy
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [119:0] m_axis_tdata_o,  // taker_id, maker_id, event_price, event_quantity
  output logic [1:0]   m_axis_tuser_o,  // event_kind
  output logic         m_axis_tlast_o
);

  lom_pkg::order_t   order;
  lom_pkg::mem_req_t mem_req;
  lom_pkg::entry_t   rd_entry;
  logic              emit_valid;
  lom_pkg::result_t  emit;
  logic              out_free;
  logic              out_valid_q;
  lom_pkg::result_t  out_q;

  assign order = '{is_buy: s_axis_tuser_i, qty: s_axis_tdata_i[87:56],
                   price: s_axis_tdata_i[55:32], id: s_axis_tdata_i[31:0]};

  lom_book_ram #(
    .DATA_W($bits(lom_pkg::entry_t)),
    .ADDR_W(lom_pkg::MEM_AW)
  ) u_ram (
    .clk_i,
    .re_i   (mem_req.re),
    .raddr_i(mem_req.raddr),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .rdata_o(rd_entry)
  );

  lom_engine u_engine (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .order_i     (order),
    .mem_req_o   (mem_req),
    .rd_i        (rd_entry),
    .emit_valid_o(emit_valid),
    .emit_o      (emit),
    .out_free_i  (out_free)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (emit_valid && out_free) begin
      out_valid_q <= 1'b1;
      out_q       <= emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tdata_o  = {out_q.qty, out_q.price, out_q.maker, out_q.taker};

  `LOM_ASSERT_SAME(a_idle_no_emit, s_axis_tready_o, !emit_valid, "result emitted while idle")
  `LOM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "accepted a second order at once")
  `LOM_ASSERT_NEXT(a_keep_stalled, out_valid_q && !m_axis_tready_i, out_valid_q, "stalled result lost")

endmodule
